/* sv/lsd_radix_sort_decimal_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimal radix sorter
// Shared property forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LSD_RADIX_SORT_DECIMAL_DEFINES_SVH
`define LSD_RADIX_SORT_DECIMAL_DEFINES_SVH

// same-cycle implication
`define LRSD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrsd assertion failed");

// next-cycle implication
`define LRSD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrsd assertion failed");

`endif

/* sv/lrsd_pkg.sv */
// ----------------------------------------------------------------------------
// lrsd_pkg
// Types and constants shared by the decimal radix sorter.
// ----------------------------------------------------------------------------
package lrsd_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = 31;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int RADIX    = 10;
    localparam int DIGIT_W  = 4;
    localparam int PLACE_W  = 34;
    localparam int QUOT_W   = 28;
    localparam int PROD_W   = 64;
    localparam logic [31:0] DIV10_MUL = 32'hCCCC_CCCD;
    localparam int DIV10_SHIFT = 35;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             final_key;
    } in_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic             last_out;
    } out_t;

    typedef struct packed {
        logic load;
        logic clr;
        logic rd;
        logic mul;
        logic count_dig;
        logic ps;
        logic place_init;
        logic place_dig;
        logic pass_done;
        logic out_init;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic pass_needed;
        logic idx_at_end;
        logic idx_zero;
        logic ps_last;
    } status_t;

endpackage

/* sv/lsd_radix_sort_decimal.sv */
// ----------------------------------------------------------------------------
// lsd_radix_sort_decimal
// Decimal least-significant-digit radix sorter of up to 64 keys.
// ----------------------------------------------------------------------------
// Keys load one per cycle while busy is low; a key beyond the 64th is dropped.
// The key with final_key set starts the sort, and busy stays high until the
// last sorted key has been issued. Each decimal pass counts the digits of the N
// stored keys, runs a prefix sum over the ten digit counters, places the keys
// into the other bank from the last key down and ends with pass control; each
// key step reads the bank into a register, divides by ten, then counts or writes.
// There are as many passes as the largest key has digits (none for zero).
// Sorted keys then leave in turn after a bank read, each on result for one cycle
// with result_valid high; the receiver must take every transfer as it comes.
// ----------------------------------------------------------------------------
module lsd_radix_sort_decimal
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lrsd_pkg::in_t  item,
    output lrsd_pkg::out_t result,
    output logic           result_valid
);

    lrsd_pkg::cmd_t    cmd;
    lrsd_pkg::status_t status;

    lrsd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .final_key (item.final_key),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    lrsd_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

/* sv/lrsd_datapath.sv */
// ----------------------------------------------------------------------------
// lrsd_datapath
// Key banks, digit extraction, digit counters, place value and result register.
// ----------------------------------------------------------------------------
`include "lsd_radix_sort_decimal_defines.svh"

module lrsd_datapath
(
    input  logic            clk,
    input  logic            rst_n,
    input  lrsd_pkg::in_t   item,
    input  lrsd_pkg::cmd_t  cmd,
    output lrsd_pkg::status_t status,
    output lrsd_pkg::out_t  result,
    output logic            result_valid
);

    localparam int ENT_W = 2 * lrsd_pkg::KEY_W;

    logic [ENT_W-1:0] mem0 [lrsd_pkg::MAX_KEYS];
    logic [ENT_W-1:0] mem1 [lrsd_pkg::MAX_KEYS];

    logic [lrsd_pkg::CNT_W-1:0]   count_reg;
    logic [lrsd_pkg::KEY_W-1:0]   largest_reg;
    logic [lrsd_pkg::PLACE_W-1:0] place_reg;
    logic                         bank_reg;
    logic [lrsd_pkg::IDX_W-1:0]   idx_reg;
    logic [lrsd_pkg::DIGIT_W-1:0] ps_idx_reg;
    logic [lrsd_pkg::CNT_W-1:0]   acc_reg;
    logic [lrsd_pkg::CNT_W-1:0]   cnt_reg [lrsd_pkg::RADIX];
    logic [ENT_W-1:0]             rd_reg;
    logic [lrsd_pkg::PROD_W-1:0]  prod_reg;
    lrsd_pkg::out_t               result_reg;
    logic                         result_valid_reg;

    logic [lrsd_pkg::KEY_W-1:0]   rd_key;
    logic [lrsd_pkg::KEY_W-1:0]   rd_q;
    logic [lrsd_pkg::QUOT_W-1:0]  quot;
    logic [lrsd_pkg::KEY_W-1:0]   quot_x10;
    logic [lrsd_pkg::KEY_W-1:0]   rem_full;
    logic [lrsd_pkg::DIGIT_W-1:0] rem;
    logic [lrsd_pkg::CNT_W-1:0]   pos_next;
    logic [lrsd_pkg::CNT_W-1:0]   acc_next;
    logic [lrsd_pkg::PLACE_W-1:0] place_next;
    logic                         room;
    logic [ENT_W-1:0]             wr_ent;

    assign rd_key   = rd_reg[ENT_W-1:lrsd_pkg::KEY_W];
    assign rd_q     = rd_reg[lrsd_pkg::KEY_W-1:0];
    assign quot     = prod_reg[lrsd_pkg::DIV10_SHIFT +: lrsd_pkg::QUOT_W];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem_full = rd_q - quot_x10;
    assign rem      = rem_full[lrsd_pkg::DIGIT_W-1:0];
    assign pos_next = cnt_reg[rem] - 1'b1;
    assign acc_next = acc_reg + cnt_reg[ps_idx_reg];
    assign place_next = (place_reg << 3) + (place_reg << 1);
    assign room     = count_reg < lrsd_pkg::CNT_W'(lrsd_pkg::MAX_KEYS);
    assign wr_ent   = {rd_key, 3'b000, quot};

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
            mem0[count_reg[lrsd_pkg::IDX_W-1:0]] <= {item.key, item.key};
        else if (cmd.place_dig && bank_reg)
            mem0[pos_next[lrsd_pkg::IDX_W-1:0]] <= wr_ent;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place_dig && !bank_reg)
            mem1[pos_next[lrsd_pkg::IDX_W-1:0]] <= wr_ent;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            if (bank_reg)
                rd_reg <= mem1[idx_reg];
            else
                rd_reg <= mem0[idx_reg];
        end
        if (cmd.mul)
            prod_reg <= lrsd_pkg::PROD_W'({1'b0, rd_q}) *
                        lrsd_pkg::PROD_W'(lrsd_pkg::DIV10_MUL);
        if (cmd.emit)
        begin
            result_reg.sorted_key <= rd_key;
            result_reg.last_out   <= status.idx_at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            largest_reg      <= '0;
            place_reg        <= lrsd_pkg::PLACE_W'(1);
            bank_reg         <= 1'b0;
            idx_reg          <= '0;
            ps_idx_reg       <= '0;
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < lrsd_pkg::RADIX; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
            if (cmd.load && room)
            begin
                count_reg <= count_reg + 1'b1;
                if (item.key > largest_reg)
                    largest_reg <= item.key;
            end
            if (cmd.clr)
            begin
                for (int i = 0; i < lrsd_pkg::RADIX; i++)
                    cnt_reg[i] <= '0;
                acc_reg    <= '0;
                ps_idx_reg <= '0;
                idx_reg    <= '0;
            end
            if (cmd.count_dig)
            begin
                cnt_reg[rem] <= cnt_reg[rem] + 1'b1;
                idx_reg      <= idx_reg + 1'b1;
            end
            if (cmd.ps)
            begin
                cnt_reg[ps_idx_reg] <= acc_next;
                acc_reg             <= acc_next;
                ps_idx_reg          <= ps_idx_reg + 1'b1;
            end
            if (cmd.place_init)
                idx_reg <= lrsd_pkg::IDX_W'(count_reg - 1'b1);
            if (cmd.place_dig)
            begin
                cnt_reg[rem] <= pos_next;
                idx_reg      <= idx_reg - 1'b1;
            end
            if (cmd.pass_done)
            begin
                bank_reg  <= ~bank_reg;
                place_reg <= place_next;
            end
            if (cmd.out_init)
                idx_reg <= '0;
            if (cmd.emit)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.finish)
            begin
                count_reg   <= '0;
                largest_reg <= '0;
                place_reg   <= lrsd_pkg::PLACE_W'(1);
                bank_reg    <= 1'b0;
            end
        end
    end

    assign status.pass_needed = {3'b000, largest_reg} >= place_reg;
    assign status.idx_at_end  = ({1'b0, idx_reg} + 1'b1) == count_reg;
    assign status.idx_zero    = idx_reg == '0;
    assign status.ps_last     = ps_idx_reg == lrsd_pkg::DIGIT_W'(lrsd_pkg::RADIX - 1);

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    `LRSD_ASSERT_IMP(a_place_cnt_nonzero, cmd.place_dig, cnt_reg[rem] != '0)
    `LRSD_ASSERT_IMP(a_digit_range, cmd.count_dig || cmd.place_dig,
                     rem < lrsd_pkg::DIGIT_W'(lrsd_pkg::RADIX))
    `LRSD_ASSERT_NXT(a_emit_strobe, cmd.emit, result_valid)

endmodule

/* sv/lrsd_ctrl.sv */
// ----------------------------------------------------------------------------
// lrsd_ctrl
// Sequencer for load, counting, prefix sum, placement and output transfers.
// ----------------------------------------------------------------------------
`include "lsd_radix_sort_decimal_defines.svh"

module lrsd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              final_key,
    input  lrsd_pkg::status_t status,
    output lrsd_pkg::cmd_t    cmd,
    output logic              busy
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CHECK  = 13'b0000000000010,
        S_CLR    = 13'b0000000000100,
        S_C_RD   = 13'b0000000001000,
        S_C_MUL  = 13'b0000000010000,
        S_C_DIG  = 13'b0000000100000,
        S_PS     = 13'b0000001000000,
        S_P_RD   = 13'b0000010000000,
        S_P_MUL  = 13'b0000100000000,
        S_P_WR   = 13'b0001000000000,
        S_NEXT   = 13'b0010000000000,
        S_O_RD   = 13'b0100000000000,
        S_O_EMIT = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (final_key)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.pass_needed)
                    state_next = S_CLR;
                else
                begin
                    cmd.out_init = 1'b1;
                    state_next   = S_O_RD;
                end
            end
            S_CLR:
            begin
                cmd.clr    = 1'b1;
                state_next = S_C_RD;
            end
            S_C_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_C_MUL;
            end
            S_C_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_C_DIG;
            end
            S_C_DIG:
            begin
                cmd.count_dig = 1'b1;
                state_next    = status.idx_at_end ? S_PS : S_C_RD;
            end
            S_PS:
            begin
                cmd.ps = 1'b1;
                if (status.ps_last)
                begin
                    cmd.place_init = 1'b1;
                    state_next     = S_P_RD;
                end
            end
            S_P_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_P_MUL;
            end
            S_P_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_P_WR;
            end
            S_P_WR:
            begin
                cmd.place_dig = 1'b1;
                state_next    = status.idx_zero ? S_NEXT : S_P_RD;
            end
            S_NEXT:
            begin
                cmd.pass_done = 1'b1;
                state_next    = S_CHECK;
            end
            S_O_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_O_EMIT;
            end
            S_O_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.idx_at_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_O_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != S_IDLE;

    `LRSD_ASSERT_NXT(a_final_starts_sort, start && !busy && final_key, state_reg == S_CHECK)
    `LRSD_ASSERT_NXT(a_pass_loops_back, state_reg == S_NEXT, state_reg == S_CHECK)
    `LRSD_ASSERT_IMP(a_finish_on_last, cmd.finish, cmd.emit && status.idx_at_end)

endmodule
